// ===== design/dnsv_pkg.sv =====
package dnsv_pkg;

    typedef enum logic [4:0] {
        PH_TYPE_START  = 5'd0,
        PH_KEY_REST    = 5'd1,
        PH_OID_START   = 5'd2,
        PH_OID_ZERO    = 5'd3,
        PH_OID_NUM     = 5'd4,
        PH_STR_LEAD    = 5'd5,
        PH_STR_BODY    = 5'd6,
        PH_STR_BODY_SP = 5'd7,
        PH_STR_ESC     = 5'd8,
        PH_STR_ESC_HEX = 5'd9,
        PH_STR_UTF     = 5'd10,
        PH_STR_UTF_F4  = 5'd11,
        PH_HEX_SHARP   = 5'd12,
        PH_HEX_PAIR1   = 5'd13,
        PH_HEX_PAIRS   = 5'd14
    } phase_t;

    localparam logic [1:0] RNG_CONT = 2'd0;
    localparam logic [1:0] RNG_E0   = 2'd1;
    localparam logic [1:0] RNG_ED   = 2'd2;
    localparam logic [1:0] RNG_F0   = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SHARP  = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int QDepth = 2;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       digit;
        logic       alpha;
        logic       xdigit;
        logic       escaped;
        logic       special;
        logic       sep;
    } byte_class_t;

endpackage

// ===== design/dnsv_front.sv =====
module dnsv_front (
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic                  q_full,
    output logic                  q_push,
    output dnsv_pkg::byte_class_t q_entry
);

    logic is_digit;
    logic is_alpha;
    logic is_esc;

    assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    assign is_alpha = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ||
                      ((data_byte >= 8'h61) && (data_byte <= 8'h7A));
    assign is_esc   = (data_byte == 8'h22) || (data_byte == dnsv_pkg::CH_PLUS) ||
                      (data_byte == dnsv_pkg::CH_COMMA) || (data_byte == 8'h3B) ||
                      (data_byte == 8'h3C) || (data_byte == 8'h3E);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_entry.data    = data_byte;
        q_entry.last    = last_byte;
        q_entry.digit   = is_digit;
        q_entry.alpha   = is_alpha;
        q_entry.xdigit  = is_digit ||
                          ((data_byte >= 8'h41) && (data_byte <= 8'h46)) ||
                          ((data_byte >= 8'h61) && (data_byte <= 8'h66));
        q_entry.escaped = is_esc;
        q_entry.special = is_esc || (data_byte == dnsv_pkg::CH_SPACE) ||
                          (data_byte == dnsv_pkg::CH_SHARP) ||
                          (data_byte == dnsv_pkg::CH_EQUALS);
        q_entry.sep     = (data_byte == dnsv_pkg::CH_COMMA) ||
                          (data_byte == dnsv_pkg::CH_PLUS);
    end

endmodule

// ===== design/dnsv_queue.sv =====
module dnsv_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  dnsv_pkg::byte_class_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output dnsv_pkg::byte_class_t head_entry
);

    dnsv_pkg::byte_class_t mem_reg [dnsv_pkg::QDepth];
    logic [dnsv_pkg::QAw-1:0] wr_ptr_reg;
    logic [dnsv_pkg::QAw-1:0] wr_ptr_next;
    logic [dnsv_pkg::QAw-1:0] rd_ptr_reg;
    logic [dnsv_pkg::QAw-1:0] rd_ptr_next;
    logic [dnsv_pkg::QCw-1:0] count_reg;
    logic [dnsv_pkg::QCw-1:0] count_next;

    assign full       = (count_reg == dnsv_pkg::QCw'(dnsv_pkg::QDepth));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dnsv_pkg::QAw'(dnsv_pkg::QDepth - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dnsv_pkg::QAw'(dnsv_pkg::QDepth - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== design/dnsv_parser.sv =====
module dnsv_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  dnsv_pkg::byte_class_t head_entry,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  dn_valid
);

    dnsv_pkg::phase_t phase_reg;
    dnsv_pkg::phase_t phase_next;
    dnsv_pkg::phase_t phase_adv;
    logic             dot_reg;
    logic             dot_next;
    logic             dot_adv;
    logic [1:0]       pend_reg;
    logic [1:0]       pend_next;
    logic [1:0]       pend_adv;
    logic [1:0]       pend_dec;
    logic [1:0]       range_reg;
    logic [1:0]       range_next;
    logic [1:0]       range_adv;
    logic             nib_reg;
    logic             nib_next;
    logic             nib_adv;
    logic             err_reg;
    logic             err_next;
    logic             err_adv;
    logic             ok;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             dn_valid_reg;
    logic             dn_valid_next;
    logic             in_range;
    logic [7:0]       c;

    assign c        = head_entry.data;
    assign pend_dec = pend_reg - 1'b1;
    assign pop      = head_valid && (!head_entry.last || !out_valid_reg || out_ready);

    always_comb
    begin
        case (range_reg)
            dnsv_pkg::RNG_E0: in_range = (c >= 8'hA0) && (c <= 8'hBF);
            dnsv_pkg::RNG_ED: in_range = (c >= 8'h80) && (c <= 8'h9F);
            dnsv_pkg::RNG_F0: in_range = (c >= 8'h90) && (c <= 8'hBF);
            default:          in_range = (c >= 8'h80) && (c <= 8'hBF);
        endcase
    end

    // Next-state logic: one parser step on the byte at the head of the queue.
    always_comb
    begin
        phase_adv = phase_reg;
        dot_adv   = dot_reg;
        pend_adv  = pend_reg;
        range_adv = range_reg;
        nib_adv   = nib_reg;
        err_adv   = 1'b0;
        unique case (phase_reg) inside
            dnsv_pkg::PH_TYPE_START:
            begin
                if (head_entry.alpha)
                begin
                    phase_adv = dnsv_pkg::PH_KEY_REST;
                end
                else if (head_entry.digit)
                begin
                    dot_adv   = 1'b0;
                    phase_adv = (c == dnsv_pkg::CH_ZERO) ? dnsv_pkg::PH_OID_ZERO :
                                                           dnsv_pkg::PH_OID_NUM;
                end
                else
                begin
                    err_adv = 1'b1;
                end
            end
            dnsv_pkg::PH_KEY_REST:
            begin
                if (head_entry.alpha || head_entry.digit || c == dnsv_pkg::CH_MINUS)
                begin
                    phase_adv = phase_reg;
                end
                else if (c == dnsv_pkg::CH_EQUALS)
                begin
                    phase_adv = dnsv_pkg::PH_STR_LEAD;
                end
                else
                begin
                    err_adv = 1'b1;
                end
            end
            dnsv_pkg::PH_OID_START:
            begin
                if (head_entry.digit)
                begin
                    phase_adv = (c == dnsv_pkg::CH_ZERO) ? dnsv_pkg::PH_OID_ZERO :
                                                           dnsv_pkg::PH_OID_NUM;
                end
                else
                begin
                    err_adv = 1'b1;
                end
            end
            dnsv_pkg::PH_OID_ZERO, dnsv_pkg::PH_OID_NUM:
            begin
                if (phase_reg == dnsv_pkg::PH_OID_NUM && head_entry.digit)
                begin
                    phase_adv = phase_reg;
                end
                else if (c == dnsv_pkg::CH_DOT)
                begin
                    dot_adv   = 1'b1;
                    phase_adv = dnsv_pkg::PH_OID_START;
                end
                else if (c == dnsv_pkg::CH_EQUALS && dot_reg)
                begin
                    phase_adv = dnsv_pkg::PH_HEX_SHARP;
                end
                else
                begin
                    err_adv = 1'b1;
                end
            end
            dnsv_pkg::PH_STR_LEAD, dnsv_pkg::PH_STR_BODY, dnsv_pkg::PH_STR_BODY_SP:
            begin
                if (phase_reg == dnsv_pkg::PH_STR_LEAD &&
                    (c == dnsv_pkg::CH_SPACE || c == dnsv_pkg::CH_SHARP))
                begin
                    err_adv = 1'b1;
                end
                else if (c[7])
                begin
                    range_adv = dnsv_pkg::RNG_CONT;
                    phase_adv = dnsv_pkg::PH_STR_UTF;
                    if (c >= 8'hC2 && c <= 8'hDF)
                    begin
                        pend_adv = 2'd1;
                    end
                    else if (c >= 8'hE0 && c <= 8'hEF)
                    begin
                        pend_adv = 2'd2;
                        if (c == 8'hE0)
                        begin
                            range_adv = dnsv_pkg::RNG_E0;
                        end
                        else if (c == 8'hED)
                        begin
                            range_adv = dnsv_pkg::RNG_ED;
                        end
                    end
                    else if (c >= 8'hF0 && c <= 8'hF4)
                    begin
                        pend_adv = 2'd3;
                        if (c == 8'hF0)
                        begin
                            range_adv = dnsv_pkg::RNG_F0;
                        end
                        else if (c == 8'hF4)
                        begin
                            phase_adv = dnsv_pkg::PH_STR_UTF_F4;
                        end
                    end
                    else
                    begin
                        err_adv = 1'b1;
                    end
                end
                else if (head_entry.sep)
                begin
                    if (phase_reg != dnsv_pkg::PH_STR_BODY)
                    begin
                        err_adv = 1'b1;
                    end
                    else
                    begin
                        phase_adv = dnsv_pkg::PH_TYPE_START;
                    end
                end
                else if (c == dnsv_pkg::CH_NUL || head_entry.escaped)
                begin
                    err_adv = 1'b1;
                end
                else if (c == dnsv_pkg::CH_BSLASH)
                begin
                    phase_adv = dnsv_pkg::PH_STR_ESC;
                end
                else
                begin
                    phase_adv = (c == dnsv_pkg::CH_SPACE) ? dnsv_pkg::PH_STR_BODY_SP :
                                                            dnsv_pkg::PH_STR_BODY;
                end
            end
            dnsv_pkg::PH_STR_ESC:
            begin
                if (c == dnsv_pkg::CH_BSLASH || head_entry.special)
                begin
                    phase_adv = dnsv_pkg::PH_STR_BODY;
                end
                else if (head_entry.xdigit)
                begin
                    phase_adv = dnsv_pkg::PH_STR_ESC_HEX;
                end
                else
                begin
                    err_adv = 1'b1;
                end
            end
            dnsv_pkg::PH_STR_ESC_HEX:
            begin
                if (head_entry.xdigit)
                begin
                    phase_adv = dnsv_pkg::PH_STR_BODY;
                end
                else
                begin
                    err_adv = 1'b1;
                end
            end
            dnsv_pkg::PH_STR_UTF, dnsv_pkg::PH_STR_UTF_F4:
            begin
                if ((phase_reg == dnsv_pkg::PH_STR_UTF && in_range) ||
                    (phase_reg == dnsv_pkg::PH_STR_UTF_F4 && c >= 8'h80 && c <= 8'h8F))
                begin
                    range_adv = dnsv_pkg::RNG_CONT;
                    pend_adv  = pend_dec;
                    phase_adv = (pend_dec == 2'd0) ? dnsv_pkg::PH_STR_BODY :
                                                     dnsv_pkg::PH_STR_UTF;
                end
                else
                begin
                    err_adv = 1'b1;
                end
            end
            dnsv_pkg::PH_HEX_SHARP:
            begin
                if (c == dnsv_pkg::CH_SHARP)
                begin
                    nib_adv   = 1'b0;
                    phase_adv = dnsv_pkg::PH_HEX_PAIR1;
                end
                else
                begin
                    err_adv = 1'b1;
                end
            end
            dnsv_pkg::PH_HEX_PAIR1:
            begin
                if (head_entry.xdigit)
                begin
                    if (nib_reg)
                    begin
                        phase_adv = dnsv_pkg::PH_HEX_PAIRS;
                    end
                    nib_adv = !nib_reg;
                end
                else
                begin
                    err_adv = 1'b1;
                end
            end
            dnsv_pkg::PH_HEX_PAIRS:
            begin
                if (head_entry.xdigit)
                begin
                    nib_adv = !nib_reg;
                end
                else if (head_entry.sep && !nib_reg)
                begin
                    phase_adv = dnsv_pkg::PH_TYPE_START;
                end
                else
                begin
                    err_adv = 1'b1;
                end
            end
            default:
            begin
                err_adv = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        dot_next   = dot_reg;
        pend_next  = pend_reg;
        range_next = range_reg;
        nib_next   = nib_reg;
        err_next   = err_reg;
        if (pop)
        begin
            if (err_reg || err_adv)
            begin
                err_next = 1'b1;
            end
            else
            begin
                phase_next = phase_adv;
                dot_next   = dot_adv;
                pend_next  = pend_adv;
                range_next = range_adv;
                nib_next   = nib_adv;
            end
            if (head_entry.last)
            begin
                phase_next = dnsv_pkg::PH_TYPE_START;
                dot_next   = 1'b0;
                pend_next  = 2'd0;
                range_next = dnsv_pkg::RNG_CONT;
                nib_next   = 1'b0;
                err_next   = 1'b0;
            end
        end
    end

    // Output logic: verdict of the name and the result register.
    always_comb
    begin
        ok = !err_reg && !err_adv &&
             (phase_adv == dnsv_pkg::PH_STR_BODY ||
              (phase_adv == dnsv_pkg::PH_HEX_PAIRS && !nib_adv));
        out_valid_next = out_valid_reg && !out_ready;
        dn_valid_next  = dn_valid_reg;
        if (pop && head_entry.last)
        begin
            out_valid_next = 1'b1;
            dn_valid_next  = ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= dnsv_pkg::PH_TYPE_START;
            dot_reg       <= 1'b0;
            pend_reg      <= 2'd0;
            range_reg     <= dnsv_pkg::RNG_CONT;
            nib_reg       <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            dot_reg       <= dot_next;
            pend_reg      <= pend_next;
            range_reg     <= range_next;
            nib_reg       <= nib_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dn_valid_reg <= dn_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign dn_valid  = dn_valid_reg;

endmodule

// ===== design/dn_syntax_validator.sv =====
// Distinguished name syntax checker. Send the name one byte per request, with
// last_byte set on its final byte; one request on the output then carries
// dn_valid, 1 for a name that follows the RFC 4514 syntax and 0 otherwise, and
// the checker is ready for the next name at once. It takes one byte every clock:
// the parser advances its state once per byte. A two-entry queue sits between
// the input stage and the parser and a result register sits after it, so bytes
// keep flowing while a verdict waits; the verdict appears in the cycle after
// the parser takes the last byte, and input stalls only when the output is
// held back and the queue has filled. No clearing is needed after reset.
module dn_syntax_validator (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       dn_valid
);

    dnsv_pkg::byte_class_t push_entry;
    dnsv_pkg::byte_class_t head_entry;
    logic                  q_full;
    logic                  q_push;
    logic                  q_pop;
    logic                  head_valid;

    dnsv_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    dnsv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    dnsv_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .dn_valid   (dn_valid)
    );

endmodule

// ===== design/dnsv_checker.sv =====
module dnsv_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] data_byte,
    input logic       last_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic       dn_valid
);

    logic [2:0] names_open_reg;
    logic [2:0] names_open_next;
    logic       name_in;
    logic       name_out;

    assign name_in  = in_valid && in_ready && last_byte;
    assign name_out = out_valid && out_ready;

    always_comb
    begin
        names_open_next = names_open_reg;
        if (name_in && !name_out)
        begin
            names_open_next = names_open_reg + 1'b1;
        end
        else if (name_out && !name_in)
        begin
            names_open_next = names_open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            names_open_reg <= '0;
        end
        else
        begin
            names_open_reg <= names_open_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dn_valid))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> names_open_reg != 3'd0)
        else $error("result without a finished name");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        names_open_reg <= 3'd3)
        else $error("more names in flight than queue and result register hold");

    a_first_wait: assert property (@(posedge clk) disable iff (!rst_n)
        names_open_reg == 3'd0 && !name_in |=> !out_valid)
        else $error("result appeared with no name pending");

endmodule

bind dn_syntax_validator dnsv_checker u_dnsv_checker (.*);
